>>> hdl/buddy_page_allocator_defines.svh
// Assertion macros used by the allocator's top-level RTL.
`ifndef BUDDY_PAGE_ALLOCATOR_DEFINES_SVH
`define BUDDY_PAGE_ALLOCATOR_DEFINES_SVH

// cond must never hold while out of reset
`define BPA_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// cons holds in the same cycle as ante
`define BPA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// cons holds in the cycle after ante
`define BPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hdl/bpa_pkg.sv
`timescale 1ns / 1ps

package bpa_pkg;

	localparam int PAGE_COUNT  = 4096;
	localparam int ORDER_LIMIT = 11;
	localparam int PAGE_W      = 12;
	localparam int LINK_W      = 13;
	localparam int ORD_W       = 4;

	localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(PAGE_COUNT);

	localparam logic [1:0] RES_DONE     = 2'd0;
	localparam logic [1:0] RES_NO_BLOCK = 2'd1;
	localparam logic [1:0] RES_BAD      = 2'd2;

	typedef struct packed {
		logic              command;
		logic [ORD_W-1:0]  block_order;
		logic [PAGE_W-1:0] page_number;
	} cmd_word_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [PAGE_W-1:0] granted_page;
		logic [LINK_W-1:0] free_page_total;
	} res_word_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_CLEAR,
		DP_LOAD,
		DP_SEARCH,
		DP_READ_TGT,
		DP_READ_PAGE,
		DP_UNLINK,
		DP_SPLIT,
		DP_LINK1,
		DP_LINK2,
		DP_FREE_INIT,
		DP_BUD_READ,
		DP_MERGE,
		DP_PUT_SETUP,
		DP_ALLOC_DONE,
		DP_FREE_DONE,
		DP_SET_NOBLK,
		DP_SET_BAD
	} dp_op_t;

	typedef struct packed {
		logic bad_order;
		logic bad_free;
		logic head_ne;
		logic cur_last;
		logic cur_gt_ord;
		logic rd_free;
		logic bud_match;
		logic cmd_free;
		logic clr_done;
	} dp_flags_t;

endpackage

>>> hdl/bpa_cmd_if.sv
`timescale 1ns / 1ps

interface bpa_cmd_if;
	logic                valid;
	logic                ready;
	bpa_pkg::cmd_word_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/bpa_res_if.sv
`timescale 1ns / 1ps

interface bpa_res_if;
	logic                valid;
	logic                ready;
	bpa_pkg::res_word_t  payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> hdl/bpa_datapath.sv
`timescale 1ns / 1ps

module bpa_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  bpa_pkg::dp_op_t     op,
	input  bpa_pkg::cmd_word_t  cmd_word,
	output bpa_pkg::dp_flags_t  flags,
	output bpa_pkg::res_word_t  res_word
);
	import bpa_pkg::*;

	// per-page stores
	logic              free_mem  [PAGE_COUNT];
	logic [ORD_W-1:0]  order_mem [PAGE_COUNT];
	logic [LINK_W-1:0] next_mem  [PAGE_COUNT];
	logic [LINK_W-1:0] prev_mem  [PAGE_COUNT];

	logic              rd_free_q;
	logic [ORD_W-1:0]  rd_order_q;
	logic [LINK_W-1:0] rd_next_q;
	logic [LINK_W-1:0] rd_prev_q;

	logic [LINK_W-1:0] head_q [ORDER_LIMIT];
	logic [LINK_W-1:0] tail_q [ORDER_LIMIT];
	logic [LINK_W-1:0] free_pages_q;
	logic [LINK_W-1:0] clr_q;

	logic              cmd_q;
	logic [ORD_W-1:0]  ord_q;
	logic [PAGE_W-1:0] page_q;
	logic [ORD_W-1:0]  cur_q;
	logic [PAGE_W-1:0] pfn_q;
	logic [PAGE_W-1:0] tgt_q;
	logic [ORD_W-1:0]  tord_q;
	logic [LINK_W-1:0] last_q;
	logic [1:0]        status_q;
	logic [PAGE_W-1:0] granted_q;

	logic [LINK_W-1:0] size;
	logic [PAGE_W-1:0] cur_bit;
	logic [ORD_W-1:0]  cur_dn;
	logic [LINK_W-1:0] head_cur;
	logic [LINK_W-1:0] tail_tord;
	logic [LINK_W-1:0] tgt_link;
	logic              u_en;
	logic              clr_done;
	logic [PAGE_W-1:0] rd_addr;

	logic              free_we, free_wd;
	logic [PAGE_W-1:0] free_wa;
	logic              order_we;
	logic              next_we, prev_we;
	logic [PAGE_W-1:0] next_wa, prev_wa;
	logic [LINK_W-1:0] next_wd, prev_wd;

	assign size      = LINK_W'(1) << ord_q;
	assign cur_bit   = PAGE_W'(1) << cur_q;
	assign cur_dn    = cur_q - ORD_W'(1);
	assign head_cur  = head_q[cur_q];
	assign tail_tord = tail_q[tord_q];
	assign tgt_link  = {1'b0, tgt_q};
	assign clr_done  = (clr_q == LINK_W'(PAGE_COUNT));
	// unlink the entry just read when it is free, or the buddy being merged
	assign u_en = ((op == DP_UNLINK) && rd_free_q) || (op == DP_MERGE);

	always_comb begin
		flags.bad_order  = (ord_q >= ORD_W'(ORDER_LIMIT));
		flags.bad_free   = ((page_q & PAGE_W'(size - LINK_W'(1))) != '0)
			|| ((14'(page_q) + 14'(size)) > 14'(PAGE_COUNT))
			|| ((14'(free_pages_q) + 14'(size)) > 14'(PAGE_COUNT));
		flags.head_ne    = (head_cur != NULL_LINK);
		flags.cur_last   = (cur_q == ORD_W'(ORDER_LIMIT - 1));
		flags.cur_gt_ord = (cur_q > ord_q);
		flags.rd_free    = rd_free_q;
		flags.bud_match  = rd_free_q && (rd_order_q == cur_q);
		flags.cmd_free   = cmd_q;
		flags.clr_done   = clr_done;
	end

	assign res_word.status          = status_q;
	assign res_word.granted_page    = granted_q;
	assign res_word.free_page_total = free_pages_q;

	always_comb begin
		case (op)
			DP_READ_PAGE: rd_addr = page_q;
			DP_BUD_READ:  rd_addr = pfn_q ^ cur_bit;
			default:      rd_addr = tgt_q;
		endcase
	end

	// write ports
	always_comb begin
		free_we  = 1'b0;
		free_wa  = tgt_q;
		free_wd  = 1'b0;
		order_we = (op == DP_LINK1);
		next_we  = 1'b0;
		next_wa  = tgt_q;
		next_wd  = NULL_LINK;
		prev_we  = 1'b0;
		prev_wa  = tgt_q;
		prev_wd  = tail_tord;
		if (op == DP_CLEAR) begin
			free_we = !clr_done;
			free_wa = clr_q[PAGE_W-1:0];
		end
		if (u_en) begin
			free_we = 1'b1;
			next_we = (rd_prev_q != NULL_LINK);
			next_wa = rd_prev_q[PAGE_W-1:0];
			next_wd = rd_next_q;
			prev_we = (rd_next_q != NULL_LINK);
			prev_wa = rd_next_q[PAGE_W-1:0];
			prev_wd = rd_prev_q;
		end
		if (op == DP_LINK1) begin
			free_we = 1'b1;
			free_wd = 1'b1;
			next_we = 1'b1;
			prev_we = 1'b1;
		end
		if (op == DP_LINK2) begin
			next_we = (last_q != NULL_LINK);
			next_wa = last_q[PAGE_W-1:0];
			next_wd = tgt_link;
		end
	end

	always_ff @(posedge clk) begin
		if (free_we) free_mem[free_wa] <= free_wd;
		if (order_we) order_mem[tgt_q] <= tord_q;
		if (next_we) next_mem[next_wa] <= next_wd;
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		rd_free_q  <= free_mem[rd_addr];
		rd_order_q <= order_mem[rd_addr];
		rd_next_q  <= next_mem[rd_addr];
		rd_prev_q  <= prev_mem[rd_addr];
	end

	// list ends, free total, clear sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ORDER_LIMIT; i++) begin
				head_q[i] <= NULL_LINK;
				tail_q[i] <= NULL_LINK;
			end
			free_pages_q <= '0;
			clr_q        <= '0;
		end else begin
			if (op == DP_CLEAR && !clr_done) clr_q <= clr_q + LINK_W'(1);
			if (u_en && rd_order_q < ORD_W'(ORDER_LIMIT)) begin
				if (rd_prev_q == NULL_LINK) head_q[rd_order_q] <= rd_next_q;
				if (rd_next_q == NULL_LINK) tail_q[rd_order_q] <= rd_prev_q;
			end
			if (op == DP_LINK1) begin
				if (tail_tord == NULL_LINK) head_q[tord_q] <= tgt_link;
				tail_q[tord_q] <= tgt_link;
			end
			if (op == DP_ALLOC_DONE)
				free_pages_q <= (free_pages_q >= size) ? free_pages_q - size : '0;
			if (op == DP_FREE_DONE) free_pages_q <= free_pages_q + size;
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (op)
			DP_LOAD: begin
				cmd_q  <= cmd_word.command;
				ord_q  <= cmd_word.block_order;
				page_q <= cmd_word.page_number;
				cur_q  <= cmd_word.block_order;
			end
			DP_SEARCH: begin
				if (head_cur != NULL_LINK) begin
					pfn_q <= head_cur[PAGE_W-1:0];
					tgt_q <= head_cur[PAGE_W-1:0];
				end else if (cur_q != ORD_W'(ORDER_LIMIT - 1)) begin
					cur_q <= cur_q + ORD_W'(1);
				end
			end
			DP_SPLIT: begin
				cur_q  <= cur_dn;
				tord_q <= cur_dn;
				tgt_q  <= pfn_q | (PAGE_W'(1) << cur_dn);
			end
			DP_FREE_INIT: begin
				pfn_q <= page_q;
				cur_q <= ord_q;
			end
			DP_BUD_READ: tgt_q <= pfn_q ^ cur_bit;
			DP_MERGE: begin
				pfn_q <= pfn_q & ~cur_bit;
				cur_q <= cur_q + ORD_W'(1);
			end
			DP_PUT_SETUP: begin
				tgt_q  <= pfn_q;
				tord_q <= cur_q;
			end
			DP_LINK1: last_q <= tail_tord;
			DP_ALLOC_DONE: begin
				status_q  <= RES_DONE;
				granted_q <= pfn_q;
			end
			DP_FREE_DONE: begin
				status_q  <= RES_DONE;
				granted_q <= '0;
			end
			DP_SET_NOBLK: begin
				status_q  <= RES_NO_BLOCK;
				granted_q <= '0;
			end
			DP_SET_BAD: begin
				status_q  <= RES_BAD;
				granted_q <= '0;
			end
			default: ;
		endcase
	end

endmodule

>>> hdl/bpa_ctrl.sv
`timescale 1ns / 1ps

module bpa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  logic                out_ready,
	input  bpa_pkg::dp_flags_t  flags,
	output bpa_pkg::dp_op_t     op,
	output logic                in_ready,
	output logic                out_valid
);
	import bpa_pkg::*;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_CHECK, S_SEARCH, S_TO_RD, S_TO_WR, S_SPLIT,
		S_PO_RD, S_PO_CHK, S_PO_W1, S_PO_W2, S_F_RD, S_F_CHK, S_F_LOOP,
		S_F_BUD, S_F_DONE, S_ERR1, S_ERR2, S_OUT
	} state_t;

	state_t state_q;
	logic   in_ready_q, out_valid_q;

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	always_comb begin
		unique case (state_q)
			S_CLEAR:  op = DP_CLEAR;
			S_IDLE:   op = (in_valid && in_ready_q) ? DP_LOAD : DP_NOP;
			S_CHECK:  op = DP_NOP;
			S_SEARCH: op = DP_SEARCH;
			S_TO_RD:  op = DP_READ_TGT;
			S_TO_WR:  op = DP_UNLINK;
			S_SPLIT:  op = flags.cur_gt_ord ? DP_SPLIT : DP_ALLOC_DONE;
			S_PO_RD:  op = DP_READ_TGT;
			S_PO_CHK: op = DP_UNLINK;
			S_PO_W1:  op = DP_LINK1;
			S_PO_W2:  op = DP_LINK2;
			S_F_RD:   op = DP_READ_PAGE;
			S_F_CHK:  op = flags.rd_free ? DP_NOP : DP_FREE_INIT;
			S_F_LOOP: op = flags.cur_last ? DP_PUT_SETUP : DP_BUD_READ;
			S_F_BUD:  op = flags.bud_match ? DP_MERGE : DP_PUT_SETUP;
			S_F_DONE: op = DP_FREE_DONE;
			S_ERR1:   op = DP_SET_NOBLK;
			S_ERR2:   op = DP_SET_BAD;
			S_OUT:    op = DP_NOP;
			default:  op = DP_NOP;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			in_ready_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (flags.clr_done) begin
						state_q    <= S_IDLE;
						in_ready_q <= 1'b1;
					end
				end
				S_IDLE: begin
					if (in_valid && in_ready_q) begin
						state_q    <= S_CHECK;
						in_ready_q <= 1'b0;
					end
				end
				S_CHECK: begin
					if (flags.bad_order) state_q <= S_ERR2;
					else if (flags.cmd_free) state_q <= flags.bad_free ? S_ERR2 : S_F_RD;
					else state_q <= S_SEARCH;
				end
				S_SEARCH: begin
					if (flags.head_ne) state_q <= S_TO_RD;
					else if (flags.cur_last) state_q <= S_ERR1;
				end
				S_TO_RD:  state_q <= S_TO_WR;
				S_TO_WR:  state_q <= S_SPLIT;
				S_SPLIT: begin
					if (flags.cur_gt_ord) begin
						state_q <= S_PO_RD;
					end else begin
						state_q     <= S_OUT;
						out_valid_q <= 1'b1;
					end
				end
				S_PO_RD:  state_q <= S_PO_CHK;
				S_PO_CHK: state_q <= S_PO_W1;
				S_PO_W1:  state_q <= S_PO_W2;
				S_PO_W2:  state_q <= flags.cmd_free ? S_F_DONE : S_SPLIT;
				S_F_RD:   state_q <= S_F_CHK;
				S_F_CHK:  state_q <= flags.rd_free ? S_ERR2 : S_F_LOOP;
				S_F_LOOP: state_q <= flags.cur_last ? S_PO_RD : S_F_BUD;
				S_F_BUD:  state_q <= flags.bud_match ? S_F_LOOP : S_PO_RD;
				S_F_DONE, S_ERR1, S_ERR2: begin
					state_q     <= S_OUT;
					out_valid_q <= 1'b1;
				end
				S_OUT: begin
					if (out_ready) begin
						state_q     <= S_IDLE;
						out_valid_q <= 1'b0;
						in_ready_q  <= 1'b1;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

>>> hdl/buddy_page_allocator.sv
// Buddy page allocator over 4096 pages, block orders 0 to 10.
// req: one word per command (allocate or free a block of 2^order pages).
// rsp: one word per command: status, granted page, free-page total after it.
// Free lists are FIFO and empty after reset; seed them by freeing blocks.
// Reset: the per-page free-flag store is swept clear, one page a cycle, so req.ready
//   rises only once the sweep has covered all 4096 pages.
// One command is in flight at a time; req.ready stays low until its word
//   has been taken from rsp.
// Allocate searches the lists from the requested order upward, then splits the
//   block it finds down to that order, putting each upper half on its list.
// Free checks the page and merges it with free buddies of equal order up to
//   order 10, then puts the result on its list; bad order or free is an error.
// Command time is set by the single read port of the per-page stores: every
//   list link or buddy probe is a registered read then a write.
// A stalled rsp simply holds the word; nothing is lost.
`timescale 1ns / 1ps
`include "buddy_page_allocator_defines.svh"

module buddy_page_allocator (
	input  logic       clk,
	input  logic       arst_n,
	bpa_cmd_if.sink    req,
	bpa_res_if.source  rsp
);
	import bpa_pkg::*;

	dp_op_t    op;
	dp_flags_t flags;
	res_word_t res_word;

	// sequencer: walks search / split / merge steps
	bpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.out_ready (rsp.ready),
		.flags     (flags),
		.op        (op),
		.in_ready  (req.ready),
		.out_valid (rsp.valid)
	);

	// stores, list ends and working registers
	bpa_datapath u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.op       (op),
		.cmd_word (req.payload),
		.flags    (flags),
		.res_word (res_word)
	);

	assign rsp.payload = res_word;

	`BPA_ASSERT_NEVER(a_one_in_flight, clk, arst_n, req.ready && rsp.valid,
		"ready while result pending")
	`BPA_ASSERT_IMPL(a_total_range, clk, arst_n, rsp.valid,
		rsp.payload.free_page_total <= LINK_W'(PAGE_COUNT), "free total above page count")
	`BPA_ASSERT_IMPL(a_grant_zero, clk, arst_n, rsp.valid && rsp.payload.status != RES_DONE,
		rsp.payload.granted_page == '0, "page granted on failure")
	`BPA_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, req.valid && req.ready, !req.ready,
		"ready held after accept")

endmodule
